// ===== sv/ecb_pkg.sv =====
// Shared constants and types for the edge coverage hit map.
`timescale 1ns / 1ps

package ecb_pkg;

    localparam int MAP_ENTRIES = 65536;
    localparam int IDX_W       = $clog2(MAP_ENTRIES);
    localparam int PREV_W      = IDX_W - 1;

    localparam logic [IDX_W-1:0] MAP_MASK = IDX_W'(MAP_ENTRIES - 1);
    localparam logic [IDX_W-1:0] CLR_LAST = IDX_W'(MAP_ENTRIES - 1);

    typedef logic [1:0]       t_mode;
    typedef logic [IDX_W-1:0] t_idx;
    typedef logic [7:0]       t_count;

    localparam t_mode MODE_RECORD     = 2'd0;
    localparam t_mode MODE_REWIND     = 2'd1;
    localparam t_mode MODE_READ       = 2'd2;
    localparam t_mode MODE_READ_CLEAR = 2'd3;

endpackage

// ===== sv/ecb_in_if.sv =====
// Input item channel: mode, code location and entry index.
`timescale 1ns / 1ps

interface ecb_in_if;
    logic          valid;
    logic          ready;
    ecb_pkg::t_mode mode;
    logic [63:0]   location;
    logic [15:0]   entry_index;

    modport source (output valid, output mode, output location, output entry_index,
                    input ready);
    modport sink   (input valid, input mode, input location, input entry_index,
                    output ready);
endinterface

// ===== sv/ecb_out_if.sv =====
// Result item channel: touched index, hit count and recorded flag.
`timescale 1ns / 1ps

interface ecb_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] touched_index;
    logic [7:0]  hit_count;
    logic        recorded;

    modport source (output valid, output touched_index, output hit_count,
                    output recorded, input ready);
    modport sink   (input valid, input touched_index, input hit_count,
                    input recorded, output ready);
endinterface

// ===== sv/ecb_cfg_if.sv =====
// Configuration write channel carrying the enabled register.
`timescale 1ns / 1ps

interface ecb_cfg_if;
    logic valid;
    logic ready;
    logic data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/edge_coverage_bitmap_core.sv =====
// Edge coverage hit map core: hash, counter store and read/clear access.
//
//  channel | dir | transaction moves
//  --------+-----+---------------------------------------------
//  i_in    | in  | mode, location, entry_index
//  o_out   | out | touched_index, hit_count, recorded (one per item)
//  i_cfg   | in  | enabled bit, always ready
//
// On accept the item issues the counter read; in S_READ the registered read
// data is taken, the counter written back and the output loaded.
// After reset a clearing pass zeroes the store, all MAP_ENTRIES (65536) entries,
// with no items accepted. A stalled output holds the pending write-back; a new
// item is accepted while a finished result still waits to be taken.
`timescale 1ns / 1ps

module edge_coverage_bitmap_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    ecb_in_if.sink           i_in,
    ecb_out_if.source        o_out,
    ecb_cfg_if.sink          i_cfg
);

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_READ  = 2'd2;

    logic [1:0]           r_state, n_state;
    ecb_pkg::t_idx        r_clr_idx;
    logic                 r_enabled;
    logic [ecb_pkg::PREV_W-1:0] r_prev;

    ecb_pkg::t_mode       r_mode;
    logic                 r_rec;
    ecb_pkg::t_idx        r_idx;

    logic                 r_out_valid;
    logic [15:0]          r_out_index;
    ecb_pkg::t_count      r_out_count;
    logic                 r_out_rec;

    ecb_pkg::t_count      mem [ecb_pkg::MAP_ENTRIES];
    ecb_pkg::t_count      r_rd_data;

    logic                 in_fire;
    logic                 out_fire;
    logic                 finish;
    logic [63:0]          hash_full;
    ecb_pkg::t_idx        hash;
    ecb_pkg::t_idx        rec_idx;
    logic [31:0]          req_ext;
    ecb_pkg::t_idx        req_idx;
    logic [31:0]          idx_ext;
    ecb_pkg::t_count      count_inc;

    logic                 wr_en;
    ecb_pkg::t_idx        wr_addr;
    ecb_pkg::t_count      wr_data;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = (r_state == S_IDLE);
    assign in_fire     = i_in.valid && i_in.ready;
    assign out_fire    = r_out_valid && o_out.ready;
    assign finish      = (r_state == S_READ) && (!r_out_valid || o_out.ready);

    assign hash_full = (i_in.location >> 4) ^ (i_in.location << 8);
    assign hash      = hash_full[ecb_pkg::IDX_W-1:0] & ecb_pkg::MAP_MASK;
    assign rec_idx   = (hash ^ {1'b0, r_prev}) & ecb_pkg::MAP_MASK;
    assign req_ext   = 32'(i_in.entry_index);
    assign req_idx   = req_ext[ecb_pkg::IDX_W-1:0] & ecb_pkg::MAP_MASK;
    assign idx_ext   = 32'(r_idx);
    assign count_inc = r_rd_data + 8'd1;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: if (r_clr_idx == ecb_pkg::CLR_LAST) n_state = S_IDLE;
            S_IDLE:  if (in_fire) n_state = S_READ;
            S_READ:  if (finish) n_state = S_IDLE;
            default: n_state = S_CLEAR;
        endcase
    end

    // Write port: clearing sweep, or the write-back of the pending item
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_idx;
        wr_data = '0;
        if (r_state == S_CLEAR) begin
            wr_en   = 1'b1;
            wr_addr = r_clr_idx;
        end else if (finish) begin
            wr_en   = r_rec || (r_mode == ecb_pkg::MODE_READ_CLEAR);
            wr_data = r_rec ? count_inc : 8'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (in_fire) begin
            r_rd_data <= mem[(i_in.mode == ecb_pkg::MODE_RECORD) ? rec_idx : req_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_idx   <= '0;
            r_enabled   <= 1'b0;
            r_prev      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr_idx <= r_clr_idx + ecb_pkg::t_idx'(1);
            end
            if (i_cfg.valid) begin
                r_enabled <= i_cfg.data;
            end
            if (in_fire) begin
                if (i_in.mode == ecb_pkg::MODE_REWIND) begin
                    r_prev <= '0;
                end else if ((i_in.mode == ecb_pkg::MODE_RECORD) && r_enabled) begin
                    r_prev <= hash[ecb_pkg::IDX_W-1:1];
                end
            end
            if (finish) begin
                r_out_valid <= 1'b1;
            end else if (out_fire) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Item and result payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_mode <= i_in.mode;
            r_rec  <= (i_in.mode == ecb_pkg::MODE_RECORD) && r_enabled;
            r_idx  <= (i_in.mode == ecb_pkg::MODE_RECORD) ? rec_idx : req_idx;
        end
        if (finish) begin
            case (r_mode)
                ecb_pkg::MODE_RECORD: begin
                    r_out_index <= r_rec ? idx_ext[15:0] : 16'd0;
                    r_out_count <= r_rec ? count_inc : 8'd0;
                    r_out_rec   <= r_rec;
                end
                ecb_pkg::MODE_REWIND: begin
                    r_out_index <= 16'd0;
                    r_out_count <= 8'd0;
                    r_out_rec   <= 1'b0;
                end
                default: begin
                    r_out_index <= idx_ext[15:0];
                    r_out_count <= r_rd_data;
                    r_out_rec   <= 1'b0;
                end
            endcase
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.touched_index = r_out_index;
    assign o_out.hit_count     = r_out_count;
    assign o_out.recorded      = r_out_rec;

endmodule
